@@ rtl/sexpr_char_lexer_macros.svh @@
// Assertion macros shared by the lexer RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef SEXPR_CHAR_LEXER_MACROS_SVH
`define SEXPR_CHAR_LEXER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/scl_pkg.sv @@
package scl_pkg;

	// Longest symbol kept, and the per-line token budget.
	localparam int MAX_LEXEME = 10;
	localparam int MAX_TOKENS = 512;

	// Result field layout: eight characters in the low word, two in the high word.
	localparam int LOW_CHARS    = 8;
	localparam int HIGH_CHARS   = 2;
	localparam int LOW_W        = 8 * LOW_CHARS;
	localparam int HIGH_W       = 8 * HIGH_CHARS;
	localparam int LEXLEN_W     = 4;
	localparam int FIELD_CHARS  = LOW_CHARS + HIGH_CHARS;
	localparam int REPORT_CHARS = (MAX_LEXEME < FIELD_CHARS) ? MAX_LEXEME : FIELD_CHARS;
	localparam int LOW_REPORT   = (REPORT_CHARS < LOW_CHARS) ? REPORT_CHARS : LOW_CHARS;

	// Pending length counts 0..MAX_LEXEME; token count counts 0..MAX_TOKENS.
	localparam int LEN_W = $clog2(MAX_LEXEME + 1);
	localparam int CNT_W = $clog2(MAX_TOKENS + 1);

	// Character codes.
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_BIT    = 8'h20;

	typedef enum logic [1:0] {
		KIND_SYMBOL = 2'd0,
		KIND_LPAREN = 2'd1,
		KIND_RPAREN = 2'd2
	} token_kind_t;

endpackage

@@ rtl/sexpr_char_lexer.sv @@
// Character lexer for S-expressions: one byte per request, tokens out.
// Registered output: a byte's first token shows in the cycle after that byte.
// Throughput: one byte per cycle unless the output stalls; a paren that also ends
// a symbol yields two tokens through the single output register, holding the input.
// Reset (arst_n low, asynchronous): no pending symbol, token count zero, output empty.
`include "sexpr_char_lexer_macros.svh"

module sexpr_char_lexer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  logic [7:0]            char_code,
	input  logic                  end_marker,
	output logic                  token_valid,
	input  logic                  token_ready,
	output scl_pkg::token_kind_t  token_kind,
	output logic [63:0]           lexeme_low,
	output logic [15:0]           lexeme_high,
	output logic [3:0]            lexeme_length,
	output logic                  last_of_run
);
	import scl_pkg::*;

	// Symbol being collected. The character store has no reset: an entry is
	// only read below the current length, which covers entries written for
	// this symbol alone.
	logic [7:0]       chars_q [MAX_LEXEME];
	logic [LEN_W-1:0] pending_length_q;
	logic             pending_nonempty_q;
	logic [CNT_W-1:0] token_count_q;

	// Output register plus a one-entry hold for the paren that follows a
	// flushed symbol.
	logic             out_valid_q;
	logic             hold_valid_q;
	token_kind_t      hold_kind_q;

	logic             take_item;
	logic             is_eol;
	logic             is_lparen;
	logic             is_rparen;
	logic             is_paren;
	logic             is_space;
	logic             is_sym_char;
	logic             do_flush;
	logic             sym_emit;
	logic             paren_emit;
	logic             res_any;
	logic             res_both;
	logic [CNT_W-1:0] count_after_sym;
	logic [7:0]       char_lower;
	token_kind_t      paren_kind;
	logic [LOW_W-1:0]  sym_low;
	logic [HIGH_W-1:0] sym_high;
	logic              drain;

	// The input side waits only while the hold entry is busy, or the output
	// register is full and not being taken this cycle.
	assign char_ready  = !out_valid_q || (token_ready && !hold_valid_q);
	assign take_item   = char_valid && char_ready;
	assign token_valid = out_valid_q;
	assign drain       = out_valid_q && token_ready;

	// Byte classification. End of line overrides the byte value.
	assign is_eol      = end_marker;
	assign is_lparen   = !is_eol && (char_code == CHAR_LPAREN);
	assign is_rparen   = !is_eol && (char_code == CHAR_RPAREN);
	assign is_paren    = is_lparen || is_rparen;
	assign is_space    = !is_eol && ((char_code == CHAR_SPACE) ||
		((char_code >= CHAR_TAB) && (char_code <= CHAR_CR)));
	assign is_sym_char = !is_eol && !is_paren && !is_space;
	assign paren_kind  = is_lparen ? KIND_LPAREN : KIND_RPAREN;

	assign char_lower = ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z)) ?
		(char_code | CASE_BIT) : char_code;

	// Any delimiter ends a pending symbol. The symbol is sent only while the
	// line still has token budget; the paren is checked against the count
	// after the symbol, so a symbol that uses the last slot drops the paren.
	assign do_flush        = (is_eol || is_paren || is_space) && pending_nonempty_q;
	assign sym_emit        = do_flush && (token_count_q < CNT_W'(MAX_TOKENS));
	assign count_after_sym = token_count_q + CNT_W'(sym_emit);
	assign paren_emit      = is_paren && (count_after_sym < CNT_W'(MAX_TOKENS));
	assign res_any         = sym_emit || paren_emit;
	assign res_both        = sym_emit && paren_emit;

	// Pack the pending symbol into the result words; bytes past the length
	// read as zero.
	always_comb begin
		sym_low  = '0;
		sym_high = '0;
		for (int i = 0; i < LOW_REPORT; i++) begin
			if (LEN_W'(i) < pending_length_q) begin
				sym_low[8*i +: 8] = chars_q[i];
			end
		end
		for (int i = LOW_CHARS; i < REPORT_CHARS; i++) begin
			if (LEN_W'(i) < pending_length_q) begin
				sym_high[8*(i-LOW_CHARS) +: 8] = chars_q[i];
			end
		end
	end

	// Symbol state and per-line token count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_length_q   <= '0;
			pending_nonempty_q <= 1'b0;
			token_count_q      <= '0;
		end else if (take_item) begin
			if (is_eol) begin
				token_count_q <= '0;
			end else begin
				token_count_q <= count_after_sym + CNT_W'(paren_emit);
			end
			if (do_flush) begin
				pending_length_q   <= '0;
				pending_nonempty_q <= 1'b0;
			end else if (is_sym_char) begin
				pending_nonempty_q <= 1'b1;
				// Characters past the limit mark the symbol present but are not kept.
				if (pending_length_q < LEN_W'(MAX_LEXEME)) begin
					pending_length_q <= pending_length_q + LEN_W'(1);
				end
			end
		end
	end

	// Character store, written at the current length.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_LEXEME; i++) begin
			if (take_item && is_sym_char && (pending_length_q == LEN_W'(i))) begin
				chars_q[i] <= char_lower;
			end
		end
	end

	// Output control. A new item is only taken when the output register is
	// empty or leaving, so loading it never overwrites an unsent token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (take_item && res_any) begin
			out_valid_q  <= 1'b1;
			hold_valid_q <= res_both;
		end else if (drain) begin
			if (hold_valid_q) begin
				hold_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload. The first result is the symbol when one is sent, else
	// the paren; a held paren moves up once the symbol is taken.
	always_ff @(posedge clk) begin
		if (take_item && res_any) begin
			hold_kind_q <= paren_kind;
			if (sym_emit) begin
				token_kind    <= KIND_SYMBOL;
				lexeme_low    <= sym_low;
				lexeme_high   <= sym_high;
				lexeme_length <= LEXLEN_W'(pending_length_q);
				last_of_run   <= !paren_emit;
			end else begin
				token_kind    <= paren_kind;
				lexeme_low    <= LOW_W'(char_code);
				lexeme_high   <= '0;
				lexeme_length <= LEXLEN_W'(1);
				last_of_run   <= 1'b1;
			end
		end else if (drain && hold_valid_q) begin
			token_kind    <= hold_kind_q;
			lexeme_low    <= LOW_W'((hold_kind_q == KIND_LPAREN) ? CHAR_LPAREN : CHAR_RPAREN);
			lexeme_high   <= '0;
			lexeme_length <= LEXLEN_W'(1);
			last_of_run   <= 1'b1;
		end
	end

	// A held paren always sits behind a token in the output register.
	`SCL_ASSERT_NOW(a_hold_behind_out, hold_valid_q, out_valid_q && !char_ready,
		"held paren without an output token, or input open while holding")
	// A paren that also flushes a symbol shows the symbol first, with the paren held.
	`SCL_ASSERT_NEXT(a_double_order, take_item && res_both,
		out_valid_q && hold_valid_q && (token_kind == KIND_SYMBOL) && !last_of_run,
		"double result not ordered symbol then paren")
	// The pending flag and the stored length agree.
	`SCL_ASSERT_NOW(a_pending_len, 1'b1, pending_nonempty_q == (pending_length_q != '0),
		"pending flag and length disagree")
	// The per-line count never passes its budget.
	`SCL_ASSERT_NOW(a_count_bound, 1'b1, token_count_q <= CNT_W'(MAX_TOKENS),
		"token count beyond the line budget")

endmodule

@@ test/sexpr_char_lexer_tb.sv @@
`timescale 1ns / 100ps

module sexpr_char_lexer_tb;
	import scl_pkg::*;

	// One expected token, laid out exactly as the output ports present it.
	typedef struct {
		token_kind_t kind;
		logic [63:0] low;
		logic [15:0] high;
		logic [3:0]  length;
		logic        last;
	} token_t;

	// The scoreboard carries its own copy of the lexer state: the characters of
	// the symbol being collected, how many are stored, whether any byte of a
	// symbol has been seen at all, and how many tokens this line has produced.
	class token_scoreboard;
		logic [7:0] sym_chars [MAX_LEXEME];
		int         sym_length;
		bit         sym_open;
		int         line_tokens;
		token_t     awaited [$];
		int         errors;
		int         requests;
		int         tokens_checked;

		function void close_symbol(ref token_t made [$]);
			token_t t;
			if (sym_open) begin
				// A symbol that would go past the line budget simply disappears.
				if (line_tokens < MAX_TOKENS) begin
					t.kind = KIND_SYMBOL;
					t.low = '0;
					t.high = '0;
					t.length = sym_length[3:0];
					t.last = 1'b0;
					for (int i = 0; i < sym_length; i++) begin
						if (i < LOW_CHARS)
							t.low[8*i +: 8] = sym_chars[i];
						else
							t.high[8*(i-LOW_CHARS) +: 8] = sym_chars[i];
					end
					made = {made, t};
					line_tokens++;
				end
				sym_open = 1'b0;
				sym_length = 0;
			end
		endfunction

		function void note_request(logic [7:0] code, logic eol);
			token_t made [$];
			token_t t;
			logic [7:0] c;
			requests++;
			c = code;
			if (eol) begin
				close_symbol(made);
				line_tokens = 0;
			end else if (c == CHAR_LPAREN || c == CHAR_RPAREN) begin
				close_symbol(made);
				if (line_tokens < MAX_TOKENS) begin
					t.kind = (c == CHAR_LPAREN) ? KIND_LPAREN : KIND_RPAREN;
					t.low = {56'd0, c};
					t.high = '0;
					t.length = 4'd1;
					t.last = 1'b0;
					made = {made, t};
					line_tokens++;
				end
			end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
				close_symbol(made);
			end else begin
				if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
					c = c | CASE_BIT;
				// Characters past the lexeme limit still keep the symbol open.
				if (sym_length < MAX_LEXEME) begin
					sym_chars[sym_length] = c;
					sym_length++;
				end
				sym_open = 1'b1;
			end
			if (made.size() > 0)
				made[made.size()-1].last = 1'b1;
			foreach (made[i])
				awaited = {awaited, made[i]};
		endfunction

		function void check_token(token_kind_t kind, logic [63:0] low, logic [15:0] high,
				logic [3:0] length, logic last);
			token_t e;
			tokens_checked++;
			if (awaited.size() == 0) begin
				$error("token with no request behind it: kind %0d lexeme %h", kind, low);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (kind !== e.kind) begin
				$error("token_kind: expected %0d, got %0d", e.kind, kind);
				errors++;
			end
			if (low !== e.low) begin
				$error("lexeme_low: expected %h, got %h", e.low, low);
				errors++;
			end
			if (high !== e.high) begin
				$error("lexeme_high: expected %h, got %h", e.high, high);
				errors++;
			end
			if (length !== e.length) begin
				$error("lexeme_length: expected %0d, got %0d", e.length, length);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_of_run: expected %0b, got %0b", e.last, last);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_ready;
	logic [7:0]  char_code = 8'd0;
	logic        end_marker = 1'b0;
	logic        token_valid;
	logic        token_ready = 1'b0;
	token_kind_t token_kind;
	logic [63:0] lexeme_low;
	logic [15:0] lexeme_high;
	logic [3:0]  lexeme_length;
	logic        last_of_run;

	token_scoreboard sb = new();

	// Idle controls shared between the stimulus and the two handshake processes.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_off_request = 0;
	int items_sent = 0;
	int lines_sent = 0;

	sexpr_char_lexer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.char_code     (char_code),
		.end_marker    (end_marker),
		.token_valid   (token_valid),
		.token_ready   (token_ready),
		.token_kind    (token_kind),
		.lexeme_low    (lexeme_low),
		.lexeme_high   (lexeme_high),
		.lexeme_length (lexeme_length),
		.last_of_run   (last_of_run)
	);

	always #5 clk = ~clk;

	// Both handshakes are observed at the rising edge, where every signal still
	// holds its value from before the edge. A token leaving now was caused by an
	// earlier request, so checking before noting the new request is safe.
	always @(posedge clk) begin
		if (arst_n && token_valid && token_ready)
			sb.check_token(token_kind, lexeme_low, lexeme_high, lexeme_length, last_of_run);
		if (arst_n && char_valid && char_ready)
			sb.note_request(char_code, end_marker);
	end

	// Offer one request. Entered at a rising edge and left at the edge where the
	// request is taken, so a back-to-back request keeps valid high without a
	// second assignment in the same step.
	task automatic send_request(input logic [7:0] code, input logic eol);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= code;
		end_marker <= eol;
		do @(posedge clk); while (!char_ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], 1'b0);
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] symbol_char();
		case ($urandom_range(0, 3))
			0: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
			1: return (CHAR_UPPER_A | CASE_BIT) + 8'($urandom_range(0, 25));
			2: return 8'h30 + 8'($urandom_range(0, 9));
			default: return any_byte();
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		int w;
		w = $urandom_range(0, 5);
		return (w == 5) ? CHAR_SPACE : CHAR_TAB + 8'(w);
	endfunction

	function automatic logic [7:0] paren_char();
		return $urandom_range(0, 1) ? CHAR_LPAREN : CHAR_RPAREN;
	endfunction

	// A well-formed line with random content: words of mixed length, now and
	// then longer than the lexeme limit, separated by blanks, parens or nothing,
	// with the occasional stray end marker in the middle of the line.
	task automatic random_line();
		int words;
		int len;
		tx_idle_on = ($urandom_range(0, 3) != 0);
		rx_idle_on = ($urandom_range(0, 3) != 0);
		words = $urandom_range(1, 8);
		if ($urandom_range(0, 2) == 0)
			send_request(CHAR_LPAREN, 1'b0);
		repeat (words) begin
			if ($urandom_range(0, 99) < 75) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14)
					: $urandom_range(1, 6);
				repeat (len) send_request(symbol_char(), 1'b0);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_request(blank_char(), 1'b0);
				4, 5, 6, 7: send_request(paren_char(), 1'b0);
				8: ;
				default: send_request(any_byte(), 1'b1);
			endcase
		end
		send_request(any_byte(), 1'b1);
		lines_sent++;
	endtask

	// One line that runs past the token budget. The count is exact: 511 tokens,
	// mostly parens with a short symbol now and then, then a symbol that takes
	// the last slot and a paren right behind it that must be dropped, then more
	// traffic that is dropped as well. The receiver stalls for a long stretch
	// meanwhile, with the sender never pausing.
	task automatic flood_line();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_off_request = 300;
		repeat (MAX_TOKENS - 1) begin
			if ($urandom_range(0, 31) != 0) begin
				send_request(paren_char(), 1'b0);
			end else begin
				repeat ($urandom_range(1, 3))
					send_request((CHAR_UPPER_A | CASE_BIT) + 8'($urandom_range(0, 25)),
						1'b0);
				send_request(blank_char(), 1'b0);
			end
		end
		send_request(CHAR_UPPER_A + 8'd16, 1'b0);
		send_request(CHAR_RPAREN, 1'b0);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (20) begin
			case ($urandom_range(0, 2))
				0: send_request(paren_char(), 1'b0);
				1: send_request(symbol_char(), 1'b0);
				default: send_request(blank_char(), 1'b0);
			endcase
		end
		send_request(any_byte(), 1'b1);
		lines_sent++;
	endtask

	// Receiver: stalls a random number of cycles before each token, or for the
	// long hold when the stimulus asks for one.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = rx_idle_on ? $urandom_range(0, 9) : 0;
			if (hold_off_request > 0) begin
				gap = hold_off_request;
				hold_off_request = 0;
			end
			if (gap > 0) begin
				token_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			token_ready <= 1'b1;
			do @(posedge clk); while (!token_valid);
		end
	end

	initial begin
		int mark;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Byte zero and byte 0xFF form a symbol that a left paren
		// then flushes, so one request yields two tokens.
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(CHAR_LPAREN, 1'b0);
		// Both ends of the upper-case range fold; the bytes just outside do not.
		send_text("AZ@[");
		send_request(CHAR_TAB, 1'b0);
		// Twelve characters: only the first ten are kept.
		send_text("LongSymbol12");
		send_request(CHAR_CR, 1'b0);
		send_request(CHAR_RPAREN, 1'b0);
		// An end marker with nothing pending gives no token; its byte is ignored.
		send_request(CHAR_LPAREN, 1'b1);
		send_text("x");
		send_request(8'hFF, 1'b1);
		lines_sent += 2;

		while (items_sent < 130)
			random_line();
		flood_line();
		mark = items_sent;
		while (items_sent - mark < 110)
			random_line();

		char_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run: %0d requests on %0d lines, %0d tokens compared;",
			sb.requests, lines_sent, sb.tokens_checked);
		$display("  one line ran past the %0d-token budget under a long output stall.",
			MAX_TOKENS);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sexpr_char_lexer.f @@
+incdir+rtl
rtl/scl_pkg.sv
rtl/sexpr_char_lexer.sv
test/sexpr_char_lexer_tb.sv
